>>> rtl/b64e_pkg.sv
package b64e_pkg;

  // Position of the next byte within its three-byte group.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [6:0] PAD_CHAR = 7'd61;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One byte's worth of output characters, as the front part leaves them.
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;  // index of the final character of this job
    logic            ends;      // the final character closes the stream
  } job_t;

  // Maps a six-bit value onto the standard base64 alphabet.
  function automatic logic [6:0] sym(input logic [5:0] idx);
    logic [6:0] ch;
    if (idx < 6'd26) begin
      ch = 7'd65 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      ch = 7'd71 + {1'b0, idx};
    end else if (idx < 6'd62) begin
      ch = {1'b0, idx} - 7'd4;
    end else if (idx == 6'd62) begin
      ch = 7'd43;
    end else begin
      ch = 7'd47;
    end
    return ch;
  endfunction

endpackage

>>> rtl/b64e_byte_if.sv
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source(output valid, output data_byte, output final_byte, input ready);
  modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

>>> rtl/b64e_char_if.sv
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_char;

  modport source(output valid, output out_char, output last_char, input ready);
  modport sink(input valid, input out_char, input last_char, output ready);
endinterface

>>> rtl/base64_stream_encoder.sv
// Channel  Role    Payload                     Meaning
// raw      sink    data_byte[7:0], final_byte  one input byte, flag on the stream's end
// enc      source  out_char[6:0], last_char    one base64 character or '=' pad
//
// Each accepted byte is turned combinationally into a job of one to four characters
// and queued; the output side sends one character per cycle while enc is ready, from a registered stage.
// In a long stream bytes average 4/3 characters, so the output port sets the pace.
// The final byte of a stream yields at most four characters.
// Synchronous active-high reset clears the group position, the queue and the output.
// A stall on enc fills the two-entry queue before raw.ready drops.
module base64_stream_encoder (
  input  logic        clk,
  input  logic        rst,
  b64e_byte_if.sink   raw,
  b64e_char_if.source enc
);

  // Jobs travel from the front part to the back part through a short queue,
  // so the byte side keeps taking items while characters wait on the output.
  b64e_pkg::job_t new_job;
  b64e_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // The front part tracks the position within the three-byte group and the
  // leftover low bits, and builds the characters that each byte completes,
  // padding included when the byte ends the stream.
  b64e_front u_front (
    .clk  (clk),
    .rst  (rst),
    .raw  (raw),
    .full (full),
    .push (push),
    .job  (new_job)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (new_job),
    .full     (full),
    .pop      (pop),
    .head     (head_job),
    .empty    (empty)
  );

  // The back part walks through the head job one character per cycle while enc
  // is ready, and flags the stream's final character.
  b64e_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head_job),
    .empty (empty),
    .pop   (pop),
    .enc   (enc)
  );

endmodule

>>> rtl/b64e_front.sv
module b64e_front (
  input  logic          clk,
  input  logic          rst,
  b64e_byte_if.sink     raw,
  input  logic          full,
  output logic          push,
  output b64e_pkg::job_t job
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;

  assign raw.ready = !full;
  assign push      = raw.valid && !full;

  always_comb begin
    logic [7:0] b;
    logic       f;
    b             = raw.data_byte;
    f             = raw.final_byte;
    job.chars     = {4{b64e_pkg::PAD_CHAR}};
    job.last_idx  = 2'd0;
    job.ends      = 1'b0;
    phase_next    = b64e_pkg::PH_FIRST;
    leftover_next = 4'd0;
    unique case (phase)
      b64e_pkg::PH_SECOND: begin
        job.chars[0] = b64e_pkg::sym({leftover[1:0], b[7:4]});
        if (f) begin
          job.chars[1] = b64e_pkg::sym({b[3:0], 2'b00});
          job.last_idx = 2'd2;
          job.ends     = 1'b1;
        end else begin
          phase_next    = b64e_pkg::PH_THIRD;
          leftover_next = b[3:0];
        end
      end
      b64e_pkg::PH_THIRD: begin
        job.chars[0] = b64e_pkg::sym({leftover, b[7:6]});
        job.chars[1] = b64e_pkg::sym(b[5:0]);
        job.last_idx = 2'd1;
        job.ends     = f;
      end
      default: begin
        // Start of a group; the unused phase code is handled the same way.
        job.chars[0] = b64e_pkg::sym(b[7:2]);
        if (f) begin
          job.chars[1] = b64e_pkg::sym({b[1:0], 4'b0000});
          job.last_idx = 2'd3;
          job.ends     = 1'b1;
        end else begin
          phase_next    = b64e_pkg::PH_SECOND;
          leftover_next = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= b64e_pkg::PH_FIRST;
      leftover <= 4'd0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

>>> rtl/b64e_queue.sv
module b64e_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output b64e_pkg::job_t head,
  output logic           empty
);

  b64e_pkg::job_t                   slots [b64e_pkg::QUEUE_DEPTH];
  logic [b64e_pkg::QPTR_W-1:0]      wr_ptr;
  logic [b64e_pkg::QPTR_W-1:0]      rd_ptr;
  logic [b64e_pkg::QCNT_W-1:0]      count;

  assign full  = count == b64e_pkg::QCNT_W'(b64e_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + b64e_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + b64e_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + b64e_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - b64e_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/b64e_back.sv
module b64e_back (
  input  logic           clk,
  input  logic           rst,
  input  b64e_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  b64e_char_if.source    enc
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = (!enc.valid || enc.ready) && !empty;
  assign at_end = idx == head.last_idx;
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc.valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        enc.valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (enc.ready) begin
        enc.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      enc.out_char  <= head.chars[idx];
      enc.last_char <= at_end && head.ends;
    end
  end

endmodule
